/* sv/tpsa_pkg.sv */
// ----------------------------------------------------------------------------
// tpsa_pkg
// Shared types, constants and the CRC-32/MPEG-2 byte update for the
// transport stream PSI section assembler.
// ----------------------------------------------------------------------------
package tpsa_pkg;

    localparam int TS_PACKET_BYTES = 188;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int PID_W     = 13;
    localparam int PREFIX_W  = 5;
    localparam int POS_W     = 8;
    localparam int INDEX_W   = 13;
    localparam int CRC_W     = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0]       STUFF_BYTE = 8'hFF;

    // byte positions inside the 188-byte packet
    localparam logic [POS_W-1:0] POS_SYNC   = 8'd0;
    localparam logic [POS_W-1:0] POS_PID_HI = 8'd1;
    localparam logic [POS_W-1:0] POS_PID_LO = 8'd2;
    localparam logic [POS_W-1:0] POS_CTRL   = 8'd3;
    localparam logic [POS_W-1:0] POS_MAX    = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_PID   = 4'd0,
        REG_PREFIX_BYTES = 4'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]         section_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               section_end;
        logic               crc_ok;
    } t_result;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0]       b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* sv/ts_psi_section_assembler.sv */
// ----------------------------------------------------------------------------
// ts_psi_section_assembler
// Filters one PID from a transport stream byte stream and reassembles its
// PSI sections, tagging each byte with its index and the last with CRC status.
// ----------------------------------------------------------------------------
// channel  direction  signals                                   transfer when
// in       sink       i_data_byte, i_packet_start               i_in_valid & o_in_ready
// out      source     o_section_byte, o_byte_index,             o_out_valid & i_out_ready
//                     o_section_end, o_crc_ok
// cfg      sink       i_cfg_index, i_cfg_data                   i_cfg_valid & o_cfg_ready
//
// One byte per cycle while o_in_ready is high; each byte is decoded and
// CRC-updated combinationally; its result is registered in the output buffer.
// A two-entry output buffer (output register plus skid) keeps the input open
// while one result stalls; input stalls only when both entries are full.
// Reset is synchronous; the cfg port is always ready.
// ----------------------------------------------------------------------------
module ts_psi_section_assembler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_packet_start,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_section_byte,
    output logic [tpsa_pkg::INDEX_W-1:0]      o_byte_index,
    output logic                              o_section_end,
    output logic                              o_crc_ok,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tpsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpsa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tpsa_pkg::*;

    logic [PID_W-1:0]    r_target_pid;
    logic [PREFIX_W-1:0] r_prefix_bytes;

    logic [POS_W-1:0]    r_packet_pos,      n_packet_pos;
    logic [PID_W-1:0]    r_header_pid,      n_header_pid;
    logic                r_unit_start,      n_unit_start;
    logic [7:0]          r_adapt_remaining, n_adapt_remaining;
    logic [7:0]          r_pointer_remaining, n_pointer_remaining;
    logic                r_pid_match,       n_pid_match;
    logic                r_skip_rest,       n_skip_rest;
    logic                r_adapt_flag,      n_adapt_flag;
    logic                r_pointer_pending, n_pointer_pending;
    logic                r_in_section,      n_in_section;
    logic [INDEX_W-1:0]  r_section_count,   n_section_count;
    logic [INDEX_W-1:0]  r_section_total,   n_section_total;
    logic [CRC_W-1:0]    r_crc,             n_crc;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    in_fire, out_fire;
    logic    res_valid;
    t_result res;

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pid   <= '0;
            r_prefix_bytes <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TARGET_PID:   r_target_pid   <= i_cfg_data[PID_W-1:0];
                REG_PREFIX_BYTES: r_prefix_bytes <= i_cfg_data[PREFIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [POS_W-1:0]   v_pos;
        logic [POS_W-1:0]   v_k;
        logic [POS_W-1:0]   v_prefix;
        logic               v_emit;
        logic               v_restart;
        logic [INDEX_W-1:0] v_idx;
        logic [INDEX_W-1:0] v_total;
        logic [CRC_W-1:0]   v_crc;
        logic               v_end;

        n_packet_pos        = r_packet_pos;
        n_header_pid        = r_header_pid;
        n_unit_start        = r_unit_start;
        n_adapt_remaining   = r_adapt_remaining;
        n_pointer_remaining = r_pointer_remaining;
        n_pid_match         = r_pid_match;
        n_skip_rest         = r_skip_rest;
        n_adapt_flag        = r_adapt_flag;
        n_pointer_pending   = r_pointer_pending;
        n_in_section        = r_in_section;
        n_section_count     = r_section_count;
        n_section_total     = r_section_total;
        n_crc               = r_crc;
        v_emit    = 1'b0;
        v_restart = 1'b0;
        v_end     = 1'b0;
        v_prefix  = {{(POS_W-PREFIX_W){1'b0}}, r_prefix_bytes};
        v_pos     = i_packet_start ? '0 : r_packet_pos;
        v_k       = v_pos - v_prefix;

        if (in_fire) begin
            if (i_packet_start) begin
                n_header_pid        = '0;
                n_unit_start        = 1'b0;
                n_adapt_remaining   = '0;
                n_pointer_remaining = '0;
                n_pid_match         = 1'b0;
                n_skip_rest         = 1'b0;
                n_adapt_flag        = 1'b0;
                n_pointer_pending   = 1'b0;
            end
            n_packet_pos = (v_pos == POS_MAX) ? v_pos : v_pos + 8'd1;

            if (v_pos >= v_prefix && v_k < POS_W'(TS_PACKET_BYTES)) begin
                case (v_k)
                    POS_SYNC: ;
                    POS_PID_HI: begin
                        n_header_pid = {i_data_byte[4:0], 8'h00};
                        n_unit_start = i_data_byte[6];
                    end
                    POS_PID_LO: begin
                        n_header_pid = {n_header_pid[PID_W-1:8], i_data_byte};
                        n_pid_match  = ({n_header_pid[PID_W-1:8], i_data_byte}
                                        == r_target_pid);
                    end
                    POS_CTRL: begin
                        n_adapt_flag      = i_data_byte[5];
                        n_pointer_pending = n_unit_start;
                    end
                    default: begin
                        if (n_pid_match && !n_skip_rest) begin
                            if (n_adapt_flag) begin
                                n_adapt_flag      = 1'b0;
                                n_adapt_remaining = i_data_byte;
                            end else if (n_adapt_remaining != '0) begin
                                n_adapt_remaining = n_adapt_remaining - 8'd1;
                            end else if (n_pointer_pending) begin
                                n_pointer_pending   = 1'b0;
                                n_pointer_remaining = i_data_byte;
                                if (i_data_byte == 8'd0) begin
                                    n_in_section = 1'b0;
                                end
                            end else if (n_pointer_remaining != '0) begin
                                n_pointer_remaining = n_pointer_remaining - 8'd1;
                                v_emit = r_in_section;
                                // pointer region over: unfinished section is dropped
                                if (n_pointer_remaining == '0) begin
                                    n_in_section = 1'b0;
                                end
                            end else if (!n_unit_start || r_in_section) begin
                                v_emit = r_in_section;
                            end else if (i_data_byte == STUFF_BYTE) begin
                                n_skip_rest = 1'b1;
                            end else begin
                                v_emit    = 1'b1;
                                v_restart = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        v_idx   = v_restart ? '0 : r_section_count;
        v_total = v_restart ? '0 : r_section_total;
        v_crc   = crc_byte(v_restart ? CRC_INIT : r_crc, i_data_byte);
        if (v_idx == INDEX_W'(1)) begin
            v_total = {1'b0, i_data_byte[3:0], 8'h00};
        end else if (v_idx == INDEX_W'(2)) begin
            v_total = v_total + {{(INDEX_W-8){1'b0}}, i_data_byte} + INDEX_W'(3);
        end
        if (v_emit) begin
            v_end = (v_idx >= INDEX_W'(2))
                    && ({1'b0, v_idx} + (INDEX_W+1)'(1) == {1'b0, v_total});
            n_crc           = v_crc;
            n_section_total = v_total;
            n_section_count = v_idx + INDEX_W'(1);
            n_in_section    = !v_end;
            if (!v_end && n_pointer_remaining == '0 && r_pointer_remaining != '0) begin
                n_in_section = 1'b0;
            end
        end

        res_valid        = v_emit;
        res.section_byte = i_data_byte;
        res.byte_index   = v_idx;
        res.section_end  = v_end;
        res.crc_ok       = v_end && (v_crc == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_pos        <= '0;
            r_header_pid        <= '0;
            r_unit_start        <= 1'b0;
            r_adapt_remaining   <= '0;
            r_pointer_remaining <= '0;
            r_pid_match         <= 1'b0;
            r_skip_rest         <= 1'b0;
            r_adapt_flag        <= 1'b0;
            r_pointer_pending   <= 1'b0;
            r_in_section        <= 1'b0;
            r_section_count     <= '0;
            r_section_total     <= '0;
            r_crc               <= CRC_INIT;
        end else begin
            r_packet_pos        <= n_packet_pos;
            r_header_pid        <= n_header_pid;
            r_unit_start        <= n_unit_start;
            r_adapt_remaining   <= n_adapt_remaining;
            r_pointer_remaining <= n_pointer_remaining;
            r_pid_match         <= n_pid_match;
            r_skip_rest         <= n_skip_rest;
            r_adapt_flag        <= n_adapt_flag;
            r_pointer_pending   <= n_pointer_pending;
            r_in_section        <= n_in_section;
            r_section_count     <= n_section_count;
            r_section_total     <= n_section_total;
            r_crc               <= n_crc;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_section_byte = r_out.section_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_section_end  = r_out.section_end;
    assign o_crc_ok       = r_out.crc_ok;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_no_input_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_ready) |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while output stalled");

    a_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.section_end) |-> (r_out.byte_index >= INDEX_W'(2)))
        else $error("section end before header complete");

    a_crc_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.crc_ok) |-> res.section_end)
        else $error("crc status outside section end");

    a_end_closes_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.section_end) |=> !r_in_section)
        else $error("section still open after its last byte");

endmodule

/* tb/psi_section_checker.sv */
// ----------------------------------------------------------------------------
// psi_section_checker
// Watches the byte, result and register channels of the PSI section
// assembler. It tracks packet decode and section assembly for every byte
// transfer, queues the section bytes the block should emit, and compares
// each result transfer against the oldest queued byte.
// ----------------------------------------------------------------------------
module psi_section_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_packet_start,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [7:0]                        i_section_byte,
    input  logic [tpsa_pkg::INDEX_W-1:0]      i_byte_index,
    input  logic                              i_section_end,
    input  logic                              i_crc_ok,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [tpsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tpsa_pkg::*;

    logic [PID_W-1:0]    want_pid;
    logic [PREFIX_W-1:0] prefix_len;
    int                  rec_pos;
    logic [PID_W-1:0]    pkt_pid;
    logic                pkt_pusi;
    logic                pkt_hit;
    logic                pkt_skip;
    logic                adapt_next;
    logic                ptr_next;
    logic [7:0]          adapt_left;
    logic [7:0]          ptr_left;
    logic                sec_open;
    logic [INDEX_W-1:0]  sec_idx;
    logic [INDEX_W-1:0]  sec_len;
    logic [CRC_W-1:0]    sec_crc;
    t_result             expected_bytes[$];
    int                  fails = 0;
    int                  reports = 0;

    function automatic void clear_header();
        pkt_pid    = '0;
        pkt_pusi   = 1'b0;
        adapt_left = '0;
        ptr_left   = '0;
        pkt_hit    = 1'b0;
        pkt_skip   = 1'b0;
        adapt_next = 1'b0;
        ptr_next   = 1'b0;
    endfunction

    // appends one expected section byte; CRC-32/MPEG-2, bit-serial MSB first
    function automatic void add_section_byte(input logic [7:0] b);
        t_result            r;
        logic [INDEX_W-1:0] idx;
        idx = sec_idx;
        for (int i = 7; i >= 0; i--) begin
            sec_crc = (sec_crc[CRC_W-1] ^ b[i]) ? ((sec_crc << 1) ^ CRC_POLY) : (sec_crc << 1);
        end
        if (idx == 1) begin
            sec_len = {1'b0, b[3:0], 8'h00};
        end else if (idx == 2) begin
            sec_len = sec_len + {{(INDEX_W-8){1'b0}}, b} + 13'd3;
        end
        r.section_byte = b;
        r.byte_index   = idx;
        r.section_end  = (idx >= 2) && (idx + 1 == sec_len);
        r.crc_ok       = r.section_end && (sec_crc == '0);
        sec_idx = idx + 1'b1;
        expected_bytes.push_back(r);
        if (r.section_end) begin
            sec_open = 1'b0;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic s);
        int p;
        int k;
        if (s) begin
            rec_pos = 0;
            clear_header();
        end
        p = rec_pos;
        if (rec_pos < POS_MAX) begin
            rec_pos++;
        end
        if (p < prefix_len) begin
            return;
        end
        k = p - prefix_len;
        if (k >= TS_PACKET_BYTES || k == POS_SYNC) begin
            return;
        end
        if (k == POS_PID_HI) begin
            pkt_pid  = {b[4:0], 8'h00};
            pkt_pusi = b[6];
            return;
        end
        if (k == POS_PID_LO) begin
            pkt_pid[7:0] = b;
            pkt_hit = (pkt_pid == want_pid);
            return;
        end
        if (k == POS_CTRL) begin
            adapt_next = b[5];
            ptr_next   = pkt_pusi;
            return;
        end
        if (!pkt_hit || pkt_skip) begin
            return;
        end
        if (adapt_next) begin
            adapt_next = 1'b0;
            adapt_left = b;
            return;
        end
        if (adapt_left != 0) begin
            adapt_left--;
            return;
        end
        if (ptr_next) begin
            ptr_next = 1'b0;
            ptr_left = b;
            if (b == 0) begin
                sec_open = 1'b0;
            end
            return;
        end
        if (ptr_left != 0) begin
            ptr_left--;
            if (sec_open) begin
                add_section_byte(b);
            end
            // unfinished section is abandoned at the end of the pointer region
            if (ptr_left == 0) begin
                sec_open = 1'b0;
            end
            return;
        end
        if (!pkt_pusi || sec_open) begin
            if (sec_open) begin
                add_section_byte(b);
            end
            return;
        end
        if (b == STUFF_BYTE) begin
            pkt_skip = 1'b1;
            return;
        end
        sec_open = 1'b1;
        sec_idx  = '0;
        sec_len  = '0;
        sec_crc  = CRC_INIT;
        add_section_byte(b);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            want_pid   = '0;
            prefix_len = '0;
            rec_pos    = 0;
            clear_header();
            sec_open   = 1'b0;
            sec_idx    = '0;
            sec_len    = '0;
            sec_crc    = CRC_INIT;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_TARGET_PID) begin
                    want_pid = i_cfg_data[PID_W-1:0];
                end else if (i_cfg_index == REG_PREFIX_BYTES) begin
                    prefix_len = i_cfg_data[PREFIX_W-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_section_byte, i_byte_index, i_section_end, i_crc_ok};
                if (expected_bytes.size() == 0) begin
                    fails++;
                    if (reports < 10) begin
                        reports++;
                        $display("%0t: unexpected section byte %02h index %0d end %0b crc_ok %0b",
                                 $time, got.section_byte, got.byte_index,
                                 got.section_end, got.crc_ok);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (reports < 10) begin
                            reports++;
                            $display("%0t: expected byte %02h index %0d end %0b crc_ok %0b",
                                     $time, want.section_byte, want.byte_index,
                                     want.section_end, want.crc_ok);
                            $display("%0t:      got byte %02h index %0d end %0b crc_ok %0b",
                                     $time, got.section_byte, got.byte_index,
                                     got.section_end, got.crc_ok);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_data_byte, i_packet_start);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_bytes.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the PSI section assembler: a short directed stream, then
// phases of random packet records under several PID/prefix settings, with
// random handshake gaps, burst phases and one long result backpressure.
// The checker instance decides pass or fail.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpsa_pkg::*;

    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_ITEMS    = 80;
    localparam int         HOLD_AFTER     = 100;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         DRAIN_CYCLES   = 8;
    localparam logic [7:0] SYNC_BYTE      = 8'h47;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte    = '0;
    logic                  packet_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [7:0]            section_byte;
    logic [INDEX_W-1:0]    byte_index;
    logic                  section_end;
    logic                  crc_ok;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_TARGET_PID;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    int                    fail_count;
    int                    pending;

    int                    sent_items   = 0;
    bit                    no_gaps      = 1'b0;
    logic [PID_W-1:0]      gen_pid      = '0;
    logic [PREFIX_W-1:0]   gen_prefix   = '0;
    logic [7:0]            sec_tail[$];

    ts_psi_section_assembler dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_packet_start (packet_start),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_section_byte (section_byte),
        .o_byte_index   (byte_index),
        .o_section_end  (section_end),
        .o_crc_ok       (crc_ok),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    psi_section_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_packet_start (packet_start),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_section_byte (section_byte),
        .i_byte_index   (byte_index),
        .i_section_end  (section_end),
        .i_crc_ok       (crc_ok),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        packet_start <= s;
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // table_id, length header, body; most long-enough sections end in a valid CRC
    task automatic queue_section();
        logic [7:0]       sec[$];
        logic [CRC_W-1:0] c;
        logic [11:0]      slen;
        logic [7:0]       r;
        int               n;
        slen = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 300))
                                           : 12'($urandom_range(0, 24));
        r = rand_byte();
        sec.push_back(8'($urandom_range(0, 254)));
        sec.push_back({r[7:4], slen[11:8]});
        sec.push_back(slen[7:0]);
        repeat (slen) sec.push_back(rand_byte());
        n = sec.size();
        if (slen >= 4 && $urandom_range(0, 3) != 0) begin
            c = CRC_INIT;
            for (int i = 0; i < n - 4; i++) begin
                c = crc_byte(c, sec[i]);
            end
            sec[n-4] = c[31:24];
            sec[n-3] = c[23:16];
            sec[n-2] = c[15:8];
            sec[n-1] = c[7:0];
        end
        foreach (sec[i]) sec_tail.push_back(sec[i]);
    endtask

    task automatic send_record();
        logic [7:0]       rec[$];
        logic [PID_W-1:0] pid;
        logic [7:0]       r;
        logic [7:0]       alen;
        logic [7:0]       plen;
        logic             hit;
        logic             pusi;
        logic             adapt;
        logic             stuffed;
        int               pick;
        int               rec_len;
        hit     = $urandom_range(0, 9) < 8;
        pid     = hit ? gen_pid : PID_W'($urandom);
        pusi    = (sec_tail.size() == 0) ? ($urandom_range(0, 3) != 0)
                                         : ($urandom_range(0, 2) == 0);
        adapt   = $urandom_range(0, 4) == 0;
        stuffed = 1'b0;
        pick    = $urandom_range(0, 29);
        // mostly short records; now and then a full packet or one with no next start
        rec_len = gen_prefix + ((pick == 0) ? TS_PACKET_BYTES :
                                (pick == 1) ? TS_PACKET_BYTES + $urandom_range(1, 80) :
                                              $urandom_range(4, 60));
        repeat (gen_prefix) rec.push_back(rand_byte());
        rec.push_back(($urandom_range(0, 5) == 0) ? rand_byte() : SYNC_BYTE);
        r = rand_byte();
        rec.push_back({r[7], pusi, r[5], pid[12:8]});
        rec.push_back(pid[7:0]);
        r = rand_byte();
        rec.push_back({r[7:6], adapt, r[4:0]});
        if (adapt) begin
            alen = ($urandom_range(0, 9) == 0) ? rand_byte() : 8'($urandom_range(0, 6));
            rec.push_back(alen);
            repeat (alen) rec.push_back(rand_byte());
        end
        if (pusi) begin
            if (!hit || $urandom_range(0, 4) == 0) begin
                plen = 8'($urandom_range(0, 8));
            end else begin
                plen = (sec_tail.size() > 255) ? 8'hFF : 8'(sec_tail.size());
            end
            rec.push_back(plen);
            repeat (plen) begin
                if (hit && sec_tail.size() != 0) begin
                    rec.push_back(sec_tail.pop_front());
                end else begin
                    rec.push_back(rand_byte());
                end
            end
            if (hit) begin
                sec_tail.delete();
            end
        end
        while (rec.size() < rec_len) begin
            if (hit && sec_tail.size() != 0) begin
                rec.push_back(sec_tail.pop_front());
            end else if (hit && pusi && !stuffed && $urandom_range(0, 7) != 0) begin
                queue_section();
            end else begin
                stuffed = stuffed | (hit && pusi);
                rec.push_back(stuffed ? STUFF_BYTE : rand_byte());
            end
        end
        foreach (rec[i]) send_byte(rec[i], i == 0);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] pid_data,
                             input logic [CFG_DATA_W-1:0] prefix_data,
                             input bit                    burst);
        int stop_at;
        write_reg(REG_TARGET_PID, pid_data);
        write_reg(REG_PREFIX_BYTES, prefix_data);
        gen_pid    = pid_data[PID_W-1:0];
        gen_prefix = prefix_data[PREFIX_W-1:0];
        no_gaps    = burst;
        sec_tail.delete();
        stop_at = sent_items + PHASE_ITEMS;
        while (sent_items < stop_at) begin
            send_record();
        end
        wait_idle();
    endtask

    // result side: random stalls per transfer, one long hold-off during a burst
    initial begin : result_side
        int  w;
        bit  held;
        held = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && no_gaps && sent_items >= HOLD_AFTER) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            w = no_gaps ? 0 : $urandom_range(0, 15);
            if (w > 0) begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        // PID 0 at reset settings, no packet_start before it
        logic [7:0]       first_rec [9] = '{SYNC_BYTE, 8'h40, 8'h00, 8'h10, 8'h00,
                                            8'h00, 8'hB0, 8'h05, 8'h5A};
        logic [CRC_W-1:0] c;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        c = CRC_INIT;
        for (int i = 5; i < 9; i++) begin
            c = crc_byte(c, first_rec[i]);
        end
        foreach (first_rec[i]) send_byte(first_rec[i], 1'b0);
        send_byte(c[31:24], 1'b0);
        send_byte(c[23:16], 1'b0);
        send_byte(c[15:8], 1'b0);
        send_byte(c[7:0], 1'b0);
        for (int i = 0; i < 6; i++) begin
            send_byte(8'hFF, i == 0);
        end
        for (int i = 0; i < 6; i++) begin
            send_byte(8'h00, i == 0);
        end
        wait_idle();

        run_phase(16'h1FFF, 16'd16, 1'b0);
        run_phase(16'($urandom_range(0, 8191)), 16'd4, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 1'b0);
        run_phase(16'h0000, 16'h0000, 1'b1);
        run_phase(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 16)), 1'b0);

        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/tpsa_pkg.sv
sv/ts_psi_section_assembler.sv
tb/psi_section_checker.sv
tb/tb.sv
